FILE: hdl/fss_pkg.sv
// Package for the frequency sweep sequencer: widths, mode codes, register
// indexes and the configuration bundle shared by all modules.
// No dependencies.
package fss_pkg;

    // Width of the stored tuning frequency.
    localparam int FREQ_WIDTH = 32;

    // Width of the programmed frequencies and of the random word.
    localparam int CFG_W = 32;

    // Arithmetic width: one bit above the widest operand, so up steps never wrap.
    localparam int SUM_W = ((FREQ_WIDTH > CFG_W) ? FREQ_WIDTH : CFG_W) + 1;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_START_FREQ = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_STOP_FREQ  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_MODE = CFG_IDX_W'(3);

    localparam logic [CFG_W-1:0] START_FREQ_RST = CFG_W'(32'd2400000000);
    localparam logic [CFG_W-1:0] STOP_FREQ_RST  = CFG_W'(32'd2500000000);
    localparam logic [CFG_W-1:0] STEP_SIZE_RST  = CFG_W'(32'd1000000);

    typedef enum logic [1:0] {
        MODE_SAWTOOTH = 2'd0,
        MODE_TRIANGLE = 2'd1,
        MODE_RANDOM   = 2'd2,
        MODE_HOLD     = 2'd3
    } t_mode;

    typedef struct packed {
        logic [CFG_W-1:0] start_freq;
        logic [CFG_W-1:0] stop_freq;
        logic [CFG_W-1:0] step_size;
        t_mode            sweep_mode;
        logic [CFG_W-1:0] span;       // stop - start, or zero when stop is not above start
    } t_cfg;

endpackage

FILE: hdl/fss_tick_if.sv
// Tick channel: valid/ready handshake carrying one random word per transfer.
// Depends on fss_pkg.
interface fss_tick_if
    import fss_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

FILE: hdl/fss_freq_if.sv
// Result channel: valid/ready handshake carrying one new frequency per transfer.
// Depends on fss_pkg.
interface fss_freq_if
    import fss_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] new_freq;

    modport source (output valid, output new_freq, input ready);
    modport sink   (input valid, input new_freq, output ready);
endinterface

FILE: hdl/fss_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying a register
// index and write data. Depends on fss_pkg.
interface fss_cfg_if
    import fss_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output idx, output data, input ready);
    modport sink   (input valid, input idx, input data, output ready);
endinterface

FILE: hdl/fss_cfg_regs.sv
// Configuration register file of the frequency sweep sequencer. Also keeps
// the random-mode span up to date on start/stop writes. Depends on fss_pkg, fss_cfg_if.
module fss_cfg_regs
    import fss_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    fss_cfg_if.sink       i_cfg,
    output t_cfg          o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    function automatic logic [CFG_W-1:0] span_of(input logic [CFG_W-1:0] start_f,
                                                 input logic [CFG_W-1:0] stop_f);
        return (stop_f > start_f) ? (stop_f - start_f) : '0;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.idx)
                REG_START_FREQ: begin
                    n_cfg.start_freq = i_cfg.data;
                    n_cfg.span       = span_of(i_cfg.data, r_cfg.stop_freq);
                end
                REG_STOP_FREQ: begin
                    n_cfg.stop_freq = i_cfg.data;
                    n_cfg.span      = span_of(r_cfg.start_freq, i_cfg.data);
                end
                REG_STEP_SIZE: begin
                    n_cfg.step_size = i_cfg.data;
                end
                REG_SWEEP_MODE: begin
                    n_cfg.sweep_mode = t_mode'(i_cfg.data[1:0]);
                end
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_freq <= START_FREQ_RST;
            r_cfg.stop_freq  <= STOP_FREQ_RST;
            r_cfg.step_size  <= STEP_SIZE_RST;
            r_cfg.sweep_mode <= MODE_SAWTOOTH;
            r_cfg.span       <= STOP_FREQ_RST - START_FREQ_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: hdl/fss_rand_scale.sv
// Input stage: registers each tick and scales its random word by the sweep
// span, keeping the high half of the product. Depends on fss_pkg, fss_tick_if.
module fss_rand_scale
    import fss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    fss_tick_if.sink         i_tick,
    input  logic [CFG_W-1:0] i_span,
    input  logic             i_adv,
    output logic             o_vld,
    output logic [CFG_W-1:0] o_ofs
);

    logic             r_vld;
    logic [CFG_W-1:0] r_ofs;
    logic [2*CFG_W-1:0] product;

    assign product      = (2*CFG_W)'(i_tick.random_word) * (2*CFG_W)'(i_span);
    assign i_tick.ready = !r_vld || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_tick.valid && i_tick.ready) begin
            r_vld <= 1'b1;
        end else if (i_adv) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_ofs <= product[2*CFG_W-1:CFG_W];
        end
    end

    assign o_vld = r_vld;
    assign o_ofs = r_ofs;

endmodule

FILE: hdl/fss_step_core.sv
// Sweep state and result register: applies the mode rule to the current
// frequency once per tick and offers a result only when the frequency
// changes. Depends on fss_pkg, fss_freq_if.
module fss_step_core
    import fss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_vld,
    input  logic [CFG_W-1:0] i_ofs,
    output logic             o_adv,
    fss_freq_if.source       o_freq
);

    logic [FREQ_WIDTH-1:0] r_cur;
    logic                  r_down;
    logic                  r_primed;
    logic                  r_out_vld;
    logic [CFG_W-1:0]      r_out_freq;

    logic [SUM_W-1:0]      cur_x;
    logic [SUM_W-1:0]      start_x;
    logic [SUM_W-1:0]      stop_x;
    logic [SUM_W-1:0]      step_x;
    logic [SUM_W-1:0]      up_x;
    logic [SUM_W-1:0]      dn_x;
    logic [SUM_W-1:0]      next_x;
    logic [SUM_W-1:0]      next_ext;
    logic [FREQ_WIDTH-1:0] cur;
    logic [FREQ_WIDTH-1:0] next_f;
    logic                  n_down;
    logic                  change;

    assign start_x = SUM_W'(i_cfg.start_freq);
    assign stop_x  = SUM_W'(i_cfg.stop_freq);
    assign step_x  = SUM_W'(i_cfg.step_size);

    // Before the first tick the sweep starts from the start frequency.
    assign cur   = r_primed ? r_cur : start_x[FREQ_WIDTH-1:0];
    assign cur_x = SUM_W'(cur);
    assign up_x  = cur_x + step_x;
    assign dn_x  = cur_x - step_x;

    always_comb begin
        next_x = cur_x;
        n_down = r_down;
        unique case (i_cfg.sweep_mode)
            MODE_SAWTOOTH: begin
                next_x = (up_x > stop_x) ? start_x : up_x;
            end
            MODE_TRIANGLE: begin
                if (!r_down) begin
                    if (up_x >= stop_x) begin
                        next_x = stop_x;
                        n_down = 1'b1;
                    end else begin
                        next_x = up_x;
                    end
                end else begin
                    // A step that would go below zero also lands on start.
                    if (step_x > cur_x || dn_x <= start_x) begin
                        next_x = start_x;
                        n_down = 1'b0;
                    end else begin
                        next_x = dn_x;
                    end
                end
            end
            MODE_RANDOM: begin
                next_x = start_x + SUM_W'(i_ofs);
            end
            MODE_HOLD: begin
                next_x = cur_x;
            end
            default: begin
                next_x = cur_x;
            end
        endcase
    end

    assign next_f   = next_x[FREQ_WIDTH-1:0];
    assign next_ext = SUM_W'(next_f);
    assign change   = (next_f != cur);
    assign o_adv    = i_vld && (!r_out_vld || o_freq.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_down    <= 1'b0;
            r_primed  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_adv) begin
                r_cur    <= next_f;
                r_down   <= n_down;
                r_primed <= 1'b1;
            end
            if (o_adv && change) begin
                r_out_vld <= 1'b1;
            end else if (o_freq.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && change) begin
            r_out_freq <= next_ext[CFG_W-1:0];
        end
    end

    assign o_freq.valid    = r_out_vld;
    assign o_freq.new_freq = r_out_freq;

endmodule

FILE: hdl/frequency_sweep_sequencer_core.sv
// Top level of the frequency sweep sequencer: configuration registers,
// random scaling stage and sweep step stage.
// Depends on fss_pkg, fss_tick_if, fss_freq_if, fss_cfg_if and the fss_ modules.
//
//   Channel   Direction  Payload              Transfer when
//   i_tick    in         random_word[31:0]    valid && ready
//   o_freq    out        new_freq[31:0]       valid && ready
//   i_cfg     in         idx[3:0], data[31:0] valid && ready (ready is always high)
//
// One tick is accepted every cycle while the result path does not stall; its
// result, if any, passes the input register (span multiply) and then the
// result register (step, compare). A tick that leaves the frequency unchanged
// produces no result. A stalled result holds back the step stage and, through
// it, the input stage. Reset is synchronous and needs no clearing pass.
module frequency_sweep_sequencer_core
    import fss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    fss_tick_if.sink   i_tick,
    fss_freq_if.source o_freq,
    fss_cfg_if.sink    i_cfg
);

    t_cfg             cfg;
    logic             s1_vld;
    logic [CFG_W-1:0] s1_ofs;
    logic             s2_adv;

    fss_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    fss_rand_scale u_rand_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (i_tick),
        .i_span  (cfg.span),
        .i_adv   (s2_adv),
        .o_vld   (s1_vld),
        .o_ofs   (s1_ofs)
    );

    fss_step_core u_step_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_vld   (s1_vld),
        .i_ofs   (s1_ofs),
        .o_adv   (s2_adv),
        .o_freq  (o_freq)
    );

endmodule
